// ===== hdl/mfb_pkg.sv =====
// ============================================================================
// mfb_pkg
// Shared types, constants and helper functions for the meter frame builder.
// ============================================================================
package mfb_pkg;

    // Limits on the configured counts.
    localparam int MAX_PAYLOAD  = 125;
    localparam int MAX_PREAMBLE = 15;

    // Fixed frame bytes.
    localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
    localparam logic [7:0] START_BYTE    = 8'h68;
    localparam logic [7:0] STOP_BYTE     = 8'h16;
    localparam logic [7:0] LEN_EXTRA     = 8'd3;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_TYPE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_METER_ADDRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_CODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_IDENT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH = 3'd5;
    localparam int CFG_DATA_W = 56;

    // Input word codes.
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } t_res;

    typedef struct packed {
        logic [3:0]  preamble_count;
        logic [7:0]  meter_type;
        logic [55:0] meter_address;
        logic [7:0]  control_code;
        logic [15:0] data_ident;
        logic [6:0]  payload_length;
    } t_cfg;

    typedef enum logic {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } t_kind;

    // One classified work item for the back end.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
        logic [7:0] serial;
        logic       trailer;
    } t_cmd;

    // Header byte positions, counted from the start byte.
    localparam logic [3:0] HDR_START   = 4'd0;
    localparam logic [3:0] HDR_TYPE    = 4'd1;
    localparam logic [3:0] HDR_ADDR0   = 4'd2;
    localparam logic [3:0] HDR_ADDR6   = 4'd8;
    localparam logic [3:0] HDR_CTRL    = 4'd9;
    localparam logic [3:0] HDR_LEN     = 4'd10;
    localparam logic [3:0] HDR_IDENT_L = 4'd11;
    localparam logic [3:0] HDR_IDENT_H = 4'd12;
    localparam logic [3:0] HDR_SERIAL  = 4'd13;

    // Trailer byte positions.
    localparam logic [3:0] TRL_SUM   = 4'd0;
    localparam logic [3:0] TRL_STOP2 = 4'd2;

    function automatic logic [6:0] clamp_payload(input logic [6:0] len);
        if (len > 7'(MAX_PAYLOAD)) begin
            return 7'(MAX_PAYLOAD);
        end
        return len;
    endfunction

    function automatic logic [3:0] clamp_preamble(input logic [3:0] cnt);
        if (cnt > 4'(MAX_PREAMBLE)) begin
            return 4'(MAX_PREAMBLE);
        end
        return cnt;
    endfunction

endpackage

// ===== hdl/meter_frame_builder.sv =====
// ============================================================================
// meter_frame_builder
// Builds heat-meter request frames as a byte stream from start and payload words.
// ============================================================================
// Usage. Input words are pushed with push while full is low. A start word
// (req_type 0) produces the configured number of 0xFE wake-up bytes, the
// start byte 0x68, the meter type, seven address bytes (lowest first), the
// control code, the length byte, the data identifier (low byte first) and
// the serial number. Each payload word (req_type 1) produces one byte. The
// word that completes the payload, or a start word when the payload length is
// zero, also produces the checksum and two 0x16 stop bytes. A payload word
// with no frame open produces nothing.
// Result words are read like a queue: while empty is low, the oldest byte is
// on o_res, and pop takes it.
// Path: a word reaches the sequencer through a four-deep command queue, and
// the sequencer loads it into its command register before emitting its bytes.
// The sequencer emits one byte per cycle while the receiver keeps popping,
// and fetches each command from the queue in its idle state without
// emitting a byte, so it finishes each word before it takes the next.
// Reset (synchronous, active low) loads the default configuration, clears
// the serial number, closes any frame and empties the queue and output word.
// When the receiver stops popping, the sequencer halts on the held word and
// the queue keeps accepting input until it fills, then raises full.
// The user must write configuration registers through i_cfg_we, i_cfg_idx and
// i_cfg_data only while the block is idle; the block does not enforce this.
// ============================================================================
module meter_frame_builder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  mfb_pkg::t_req                       i_req,
    output logic                                full,
    input  logic                                pop,
    output logic                                empty,
    output mfb_pkg::t_res                       o_res,
    input  logic                                i_cfg_we,
    input  logic [mfb_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mfb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers, loaded with their defaults at reset.
    mfb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_count <= 4'd4;
            r_cfg.meter_type     <= 8'd32;
            r_cfg.meter_address  <= '0;
            r_cfg.control_code   <= 8'd1;
            r_cfg.data_ident     <= 16'd36895;
            r_cfg.payload_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mfb_pkg::CFG_PREAMBLE_COUNT: r_cfg.preamble_count <= i_cfg_data[3:0];
                mfb_pkg::CFG_METER_TYPE:     r_cfg.meter_type     <= i_cfg_data[7:0];
                mfb_pkg::CFG_METER_ADDRESS:  r_cfg.meter_address  <= i_cfg_data[55:0];
                mfb_pkg::CFG_CONTROL_CODE:   r_cfg.control_code   <= i_cfg_data[7:0];
                mfb_pkg::CFG_DATA_IDENT:     r_cfg.data_ident     <= i_cfg_data[15:0];
                mfb_pkg::CFG_PAYLOAD_LENGTH: r_cfg.payload_length <= i_cfg_data[6:0];
                default:                     r_cfg <= r_cfg;
            endcase
        end
    end

    // Front end to queue, queue to back end.
    logic          q_wr;
    logic          q_full;
    logic          q_rd;
    logic          q_valid;
    mfb_pkg::t_cmd q_cmd_in;
    mfb_pkg::t_cmd q_cmd_out;

    assign full = q_full;

    // The front end classifies words, follows the open frame and numbers frames.
    mfb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_req    (i_req),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_q_cmd  (q_cmd_in)
    );

    // The queue lets the front end keep taking words while bytes drain.
    mfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (q_cmd_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_cmd   (q_cmd_out)
    );

    // The back end turns each command into bytes and keeps the checksum.
    mfb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd_out),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_res)
    );

endmodule

// ===== hdl/mfb_queue.sv =====
// ============================================================================
// mfb_queue
// Short command queue that decouples the front end from the back end.
// ============================================================================
module mfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mfb_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output mfb_pkg::t_cmd o_cmd
);

    mfb_pkg::t_cmd                    r_mem [mfb_pkg::QUEUE_DEPTH];
    logic [mfb_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [mfb_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [mfb_pkg::QCNT_W-1:0]       r_count;
    logic                             wr_en;
    logic                             rd_en;

    assign o_full  = (r_count == mfb_pkg::QCNT_W'(mfb_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mfb_pkg::QCNT_W'(mfb_pkg::QUEUE_DEPTH))
        else $error("command queue count beyond depth");

endmodule

// ===== hdl/mfb_front.sv =====
// ============================================================================
// mfb_front
// Accepts input words, tracks the open frame and issues commands.
// ============================================================================
module mfb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mfb_pkg::t_cfg i_cfg,
    input  logic          i_push,
    input  mfb_pkg::t_req i_req,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output mfb_pkg::t_cmd o_q_cmd
);

    logic       r_in_frame;
    logic [6:0] r_bytes_left;
    logic [7:0] r_serial;
    logic       n_in_frame;
    logic [6:0] n_bytes_left;
    logic [7:0] n_serial;
    logic       accept;
    logic [6:0] plen;

    assign accept = i_push && !i_q_full;
    assign plen   = mfb_pkg::clamp_payload(i_cfg.payload_length);

    always_comb begin
        n_in_frame         = r_in_frame;
        n_bytes_left       = r_bytes_left;
        n_serial           = r_serial;
        o_q_wr             = 1'b0;
        o_q_cmd.kind       = mfb_pkg::CMD_START;
        o_q_cmd.data_byte  = i_req.data_byte;
        o_q_cmd.serial     = r_serial;
        o_q_cmd.trailer    = 1'b0;
        if (accept) begin
            if (i_req.req_type == mfb_pkg::REQ_START) begin
                // A start always opens a fresh frame; an empty payload closes it at once.
                o_q_wr          = 1'b1;
                o_q_cmd.trailer = (plen == '0);
                n_serial        = r_serial + 1'b1;
                n_bytes_left    = plen;
                n_in_frame      = (plen != '0);
            end else if (r_in_frame) begin
                o_q_wr          = 1'b1;
                o_q_cmd.kind    = mfb_pkg::CMD_PAYLOAD;
                o_q_cmd.trailer = (r_bytes_left == 7'd1);
                n_bytes_left    = r_bytes_left - 1'b1;
                n_in_frame      = (r_bytes_left != 7'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_serial     <= '0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
            r_serial     <= n_serial;
        end
    end

endmodule

// ===== hdl/mfb_back.sv =====
// ============================================================================
// mfb_back
// Byte sequencer: expands commands into frame bytes and holds the output word.
// ============================================================================
module mfb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mfb_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  mfb_pkg::t_cmd i_q_cmd,
    output logic          o_q_rd,
    input  logic          i_pop,
    output logic          o_empty,
    output mfb_pkg::t_res o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PRE  = 5'b00010,
        S_HDR  = 5'b00100,
        S_PAY  = 5'b01000,
        S_TRL  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    mfb_pkg::t_cmd r_cmd, n_cmd;
    logic [3:0]    r_idx, n_idx;
    logic [7:0]    r_sum, n_sum;
    mfb_pkg::t_res r_out;
    logic          r_out_valid;
    mfb_pkg::t_res emit_word;
    logic          emit;
    logic          can_emit;
    logic [3:0]    pre;
    logic [7:0]    hdr_byte;
    logic [2:0]    addr_sel;

    assign can_emit = !r_out_valid || i_pop;
    assign pre      = mfb_pkg::clamp_preamble(i_cfg.preamble_count);
    assign addr_sel = 3'(r_idx - mfb_pkg::HDR_ADDR0);

    always_comb begin
        if (r_idx >= mfb_pkg::HDR_ADDR0 && r_idx <= mfb_pkg::HDR_ADDR6) begin
            hdr_byte = i_cfg.meter_address[{addr_sel, 3'b000} +: 8];
        end else begin
            unique case (r_idx)
                mfb_pkg::HDR_START:   hdr_byte = mfb_pkg::START_BYTE;
                mfb_pkg::HDR_TYPE:    hdr_byte = i_cfg.meter_type;
                mfb_pkg::HDR_CTRL:    hdr_byte = i_cfg.control_code;
                mfb_pkg::HDR_LEN:     hdr_byte = 8'(mfb_pkg::clamp_payload(
                                          i_cfg.payload_length)) + mfb_pkg::LEN_EXTRA;
                mfb_pkg::HDR_IDENT_L: hdr_byte = i_cfg.data_ident[7:0];
                mfb_pkg::HDR_IDENT_H: hdr_byte = i_cfg.data_ident[15:8];
                mfb_pkg::HDR_SERIAL:  hdr_byte = r_cmd.serial;
                default:              hdr_byte = mfb_pkg::START_BYTE;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_sum     = r_sum;
        o_q_rd    = 1'b0;
        emit      = 1'b0;
        emit_word = '{out_byte: mfb_pkg::PREAMBLE_BYTE, run_last: 1'b0, frame_end: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_rd = 1'b1;
                    n_cmd  = i_q_cmd;
                    n_idx  = '0;
                    if (i_q_cmd.kind == mfb_pkg::CMD_START) begin
                        n_sum   = '0;
                        n_state = (pre != '0) ? S_PRE : S_HDR;
                    end else begin
                        n_state = S_PAY;
                    end
                end
            end
            S_PRE: begin
                if (can_emit) begin
                    emit = 1'b1;
                    if (r_idx == pre - 1'b1) begin
                        n_idx   = '0;
                        n_state = S_HDR;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_HDR: begin
                if (can_emit) begin
                    emit               = 1'b1;
                    emit_word.out_byte = hdr_byte;
                    n_sum              = r_sum + hdr_byte;
                    if (r_idx == mfb_pkg::HDR_SERIAL) begin
                        emit_word.run_last = !r_cmd.trailer;
                        n_idx              = '0;
                        n_state            = r_cmd.trailer ? S_TRL : S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_PAY: begin
                if (can_emit) begin
                    emit               = 1'b1;
                    emit_word.out_byte = r_cmd.data_byte;
                    emit_word.run_last = !r_cmd.trailer;
                    n_sum              = r_sum + r_cmd.data_byte;
                    n_idx              = '0;
                    n_state            = r_cmd.trailer ? S_TRL : S_IDLE;
                end
            end
            S_TRL: begin
                if (can_emit) begin
                    emit               = 1'b1;
                    emit_word.out_byte = (r_idx == mfb_pkg::TRL_SUM) ? r_sum
                                                                      : mfb_pkg::STOP_BYTE;
                    if (r_idx == mfb_pkg::TRL_STOP2) begin
                        emit_word.run_last  = 1'b1;
                        emit_word.frame_end = 1'b1;
                        n_idx               = '0;
                        n_state             = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_sum <= n_sum;
        if (emit) begin
            r_out <= emit_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.run_last)
        else $error("frame end word not flagged as last of its run");

    a_end_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_end |-> r_out.out_byte == mfb_pkg::STOP_BYTE)
        else $error("frame end word is not a stop byte");

    a_pay_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PAY |-> r_cmd.kind == mfb_pkg::CMD_PAYLOAD)
        else $error("payload state entered for a start command");

    a_trl_needs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TRL |-> r_cmd.trailer)
        else $error("trailer emitted for a command that does not close the frame");

endmodule
